@@ src/gbp_pkg.sv @@
// Shared types, constants and the helper function of the gshare branch predictor.
package gbp_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int COUNTER_BITS_DEF  = 2;

    localparam int ADDR_W     = 64;
    localparam int HIST_W     = 16;
    localparam int SHIFT_W    = 3;
    localparam int HLEN_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN   = 2'd2;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [SHIFT_W-1:0] ADDR_SHIFT_RST = 3'd2;
    localparam logic [HLEN_W-1:0]  HIST_LEN_RST   = 5'd12;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic read;
        logic exec;
    } gbp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } gbp_sts_t;

    // Lengths above sixteen keep all sixteen history bits.
    function automatic logic [HIST_W-1:0] hist_mask(input logic [HLEN_W-1:0] len);
        logic [HIST_W:0] one_hot;
        begin
            one_hot = (HIST_W+1)'(1) << len;
            if (len >= HLEN_W'(HIST_W))
            begin
                hist_mask = '1;
            end
            else
            begin
                hist_mask = HIST_W'(one_hot - (HIST_W+1)'(1));
            end
        end
    endfunction

endpackage

@@ src/gbp_ctrl.sv @@
// Controller state machine of the gshare branch predictor.
module gbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  gbp_pkg::gbp_sts_t sts,
    output gbp_pkg::gbp_cmd_t cmd
);
    import gbp_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

@@ src/gbp_datapath.sv @@
// Datapath of the gshare branch predictor: registers, history and counter table.
module gbp_datapath #(
    parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNTER_BITS  = gbp_pkg::COUNTER_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [gbp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  gbp_pkg::gbp_cmd_t                cmd,
    output gbp_pkg::gbp_sts_t                sts,
    output logic [gbp_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import gbp_pkg::*;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SLICE_W = IDX_W + 7;

    logic                    spec_reg;
    logic [SHIFT_W-1:0]      shift_reg;
    logic [HLEN_W-1:0]       hlen_reg;
    logic [HIST_W-1:0]       hist_reg;
    logic [HIST_W-1:0]       hist_next;
    logic [IDX_W-1:0]        clr_cnt_reg;

    logic                    func_reg;
    logic [SLICE_W-1:0]      addr_reg;
    logic                    taken_reg;
    logic [HIST_W-1:0]       saved_reg;
    logic                    squash_reg;

    logic [COUNTER_BITS-1:0] mem [TABLE_ENTRIES];
    logic [COUNTER_BITS-1:0] rdata_reg;
    logic [COUNTER_BITS-1:0] ctr_next;

    logic                    pred_reg;
    logic [HIST_W-1:0]       snap_reg;

    logic [SLICE_W-1:0]      addr_shifted;
    logic [HIST_W-1:0]       hist_sel;
    logic [IDX_W-1:0]        idx;
    logic                    pred;
    logic [HIST_W-1:0]       mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_reg  <= 1'b0;
            shift_reg <= ADDR_SHIFT_RST;
            hlen_reg  <= HIST_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEC_MODE:  spec_reg  <= cfg_data[0];
                CFG_ADDR_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_HIST_LEN:   hlen_reg  <= cfg_data[HLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= s_axis_tuser;
            addr_reg   <= s_axis_tdata[SLICE_W-1:0];
            taken_reg  <= s_axis_tdata[64];
            saved_reg  <= s_axis_tdata[80:65];
            squash_reg <= s_axis_tdata[81];
        end
    end

    assign addr_shifted = addr_reg >> shift_reg;
    assign hist_sel     = (func_reg == FUNC_UPDATE) ? saved_reg : hist_reg;
    assign idx          = (addr_shifted[IDX_W-1:0] ^ hist_sel[IDX_W-1:0])
                          & IDX_W'(TABLE_ENTRIES - 1);
    assign pred         = rdata_reg[COUNTER_BITS-1];
    assign mask         = hist_mask(hlen_reg);

    always_comb
    begin
        ctr_next = rdata_reg;
        if (taken_reg)
        begin
            if (rdata_reg != '1)
            begin
                ctr_next = rdata_reg + COUNTER_BITS'(1);
            end
        end
        else if (rdata_reg != '0)
        begin
            ctr_next = rdata_reg - COUNTER_BITS'(1);
        end
    end

    always_comb
    begin
        hist_next = hist_reg;
        if (func_reg == FUNC_LOOKUP)
        begin
            if (spec_reg)
            begin
                hist_next = {hist_reg[HIST_W-2:0], pred} & mask;
            end
        end
        else if (!spec_reg)
        begin
            hist_next = {hist_reg[HIST_W-2:0], taken_reg} & mask;
        end
        else if (squash_reg)
        begin
            hist_next = {saved_reg[HIST_W-2:0], taken_reg} & mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                hist_reg <= hist_next;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
        end
    end

    assign sts.clear_last = (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.exec && func_reg == FUNC_UPDATE)
        begin
            mem[idx] <= ctr_next;
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (func_reg == FUNC_LOOKUP)
            begin
                pred_reg <= pred;
                snap_reg <= hist_reg;
            end
            else
            begin
                pred_reg <= 1'b0;
                snap_reg <= '0;
            end
        end
    end

    assign m_axis_tdata = {{(M_TDATA_W - HIST_W - 1){1'b0}}, snap_reg, pred_reg};

endmodule

@@ src/gshare_branch_predictor_core.sv @@
// Top level of the gshare branch predictor: controller and datapath.
//
// From acceptance, each item is latched, the counter table is read, and then the result is
// registered, an update writes its counter back and the history moves per mode, this last
// step waiting on a stalled result. A new item is accepted only once the last is through,
// as the read-modify-write uses the single port of the counter table. After reset the table
// is swept to zero, one entry per cycle over all TABLE_ENTRIES entries (4096 by default), and
// no item is accepted until the sweep ends; configuration writes are taken at any time.
module gshare_branch_predictor_core #(
    parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNTER_BITS  = gbp_pkg::COUNTER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // branch_address, actual_taken, saved_history, squash, zero fill
    input  logic [gbp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // predict_taken, history_snapshot, zero fill
    output logic [gbp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import gbp_pkg::*;

    gbp_cmd_t cmd;
    gbp_sts_t sts;

    gbp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    gbp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .cmd          (cmd),
        .sts          (sts),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

@@ src/gbp_checker.sv @@
// Port-level assertions of the gshare branch predictor and their bind.
module gbp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gbp_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import gbp_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed.");

    // Only one transaction is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input accepted while an item is in flight.");

    // With the output free at acceptance, a result follows the read and execute states.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |-> ##3 m_axis_tvalid)
        else $error("Result did not appear on time.");

    // An update transaction yields an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_UPDATE && !m_axis_tvalid
        |-> ##3 (m_axis_tdata == '0))
        else $error("Update result is not zero.");

endmodule

bind gshare_branch_predictor_core gbp_checker u_gbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
